// File: hdl/mrf_pkg.sv
// Shared types, codes and constants for the Modbus RTU master framer.
// No dependencies; the front end, queue, sequencer and top level refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package mrf_pkg;

    // Input operation codes
    typedef enum logic [1:0] {
        OP_PDU  = 2'd0,
        OP_RX   = 2'd1,
        OP_TICK = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_VERDICT = 2'd2
    } t_kind;

    // Verdict status codes
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TIMEOUT   = 3'd1,
        ST_CRC_ERR   = 3'd2,
        ST_BAD_RESP  = 3'd3,
        ST_EXCEPTION = 3'd4
    } t_status;

    // Transaction phase
    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_H0   = 4'd1,
        PH_H1   = 4'd2,
        PH_H2   = 4'd3,
        PH_DATA = 4'd4,
        PH_ECHO = 4'd5,
        PH_CRCL = 4'd6,
        PH_CRCH = 4'd7
    } t_phase;

    // Configuration register indexes
    localparam logic [1:0] CFG_SLAVE_ADDR  = 2'd0;
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT     = 2'd2;

    localparam logic [7:0]  RST_SLAVE_ADDR  = 8'd1;
    localparam logic [7:0]  RST_MAX_PAYLOAD = 8'd250;
    localparam logic [15:0] RST_TIMEOUT     = 16'd1000;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [7:0]  EXC_FLAG    = 8'h80;
    localparam logic [7:0]  READ_FC_MAX = 8'h04;
    localparam logic [7:0]  MAX_DATA    = 8'd250;
    localparam logic [7:0]  ECHO_LEN    = 8'd6;
    localparam logic [7:0]  ECHO_START  = 8'd3;
    localparam logic [15:0] TICK_MAX    = 16'hFFFF;

    // Result queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // One queued group of results caused by one input item
    typedef struct packed {
        t_kind           kind;
        logic [1:0]      cnt;       // number of results minus one
        logic [3:0][7:0] bytes;
        t_status         status;
        logic [7:0]      exc;
        logic [7:0]      plen;
    } t_entry;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_push;

    typedef struct packed {
        logic   valid;
        t_entry entry;
    } t_head;

    // Byte-wide CRC-16 (Modbus, reflected) update
    function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'd0, b};
        for (int i = 0; i < 8; i++) begin
            if (r[0]) begin
                r = (r >> 1) ^ CRC_POLY;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hdl/mrf_in_if.sv
// Input channel: operation, data byte and last flag with valid/ready.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mrf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data_byte;
    logic       last_flag;

    modport source (output valid, output op, output data_byte, output last_flag,
                    input ready);
    modport sink   (input valid, input op, input data_byte, input last_flag,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/mrf_out_if.sv
// Result channel: kind, byte, verdict fields and last marker with valid/ready.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface mrf_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic [7:0] exception_code;
    logic [7:0] payload_len;
    logic       last;

    modport source (output valid, output kind, output out_byte, output status,
                    output exception_code, output payload_len, output last,
                    input ready);
    modport sink   (input valid, input kind, input out_byte, input status,
                    input exception_code, input payload_len, input last,
                    output ready);
endinterface

`default_nettype wire

// File: hdl/mrf_front.sv
// Front end: accepts input items, runs framing/parsing state, pushes result groups.
// Depends on mrf_pkg and mrf_in_if.
`timescale 1ns / 1ps
`default_nettype none

module mrf_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    mrf_in_if.sink             i_in,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_idx,
    input  wire logic [15:0]   i_cfg_data,
    input  wire logic          i_q_full,
    output mrf_pkg::t_push     o_push
);

    logic [7:0]      r_slave_addr;
    logic [7:0]      r_max_payload;
    logic [15:0]     r_timeout;

    mrf_pkg::t_phase r_phase,    n_phase;
    logic [7:0]      r_req_fc,   n_req_fc;
    logic [15:0]     r_crc,      n_crc;
    logic [7:0]      r_hdr_addr, n_hdr_addr;
    logic [7:0]      r_hdr_fc,   n_hdr_fc;
    logic [7:0]      r_exp_cnt,  n_exp_cnt;
    logic [7:0]      r_byte_cnt, n_byte_cnt;
    logic [7:0]      r_crc_lo,   n_crc_lo;
    logic [15:0]     r_tick,     n_tick;
    logic            r_first,    n_first;

    logic            accept;
    logic [7:0]      b;
    logic [15:0]     crc_a;
    logic [15:0]     crc_b;
    logic [15:0]     crc_rx;
    logic [7:0]      cnt_inc;
    logic [15:0]     tick_inc;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;

    // Request-side CRC: seed with the address before the first PDU byte
    assign crc_a  = r_first ? mrf_pkg::crc_feed(mrf_pkg::CRC_INIT, r_slave_addr) : r_crc;
    assign crc_b  = mrf_pkg::crc_feed(crc_a, b);
    assign crc_rx = mrf_pkg::crc_feed(r_crc, b);
    assign cnt_inc  = r_byte_cnt + 8'd1;
    assign tick_inc = (r_tick != mrf_pkg::TICK_MAX) ? r_tick + 16'd1 : r_tick;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr  <= mrf_pkg::RST_SLAVE_ADDR;
            r_max_payload <= mrf_pkg::RST_MAX_PAYLOAD;
            r_timeout     <= mrf_pkg::RST_TIMEOUT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mrf_pkg::CFG_SLAVE_ADDR:  r_slave_addr  <= i_cfg_data[7:0];
                mrf_pkg::CFG_MAX_PAYLOAD: r_max_payload <= i_cfg_data[7:0];
                mrf_pkg::CFG_TIMEOUT:     r_timeout     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Transaction state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= mrf_pkg::PH_IDLE;
            r_req_fc   <= 8'd0;
            r_crc      <= mrf_pkg::CRC_INIT;
            r_hdr_addr <= 8'd0;
            r_hdr_fc   <= 8'd0;
            r_exp_cnt  <= 8'd0;
            r_byte_cnt <= 8'd0;
            r_crc_lo   <= 8'd0;
            r_tick     <= 16'd0;
            r_first    <= 1'b1;
        end else begin
            r_phase    <= n_phase;
            r_req_fc   <= n_req_fc;
            r_crc      <= n_crc;
            r_hdr_addr <= n_hdr_addr;
            r_hdr_fc   <= n_hdr_fc;
            r_exp_cnt  <= n_exp_cnt;
            r_byte_cnt <= n_byte_cnt;
            r_crc_lo   <= n_crc_lo;
            r_tick     <= n_tick;
            r_first    <= n_first;
        end
    end

    // Next state and result group for the accepted transaction
    always_comb begin
        n_phase    = r_phase;
        n_req_fc   = r_req_fc;
        n_crc      = r_crc;
        n_hdr_addr = r_hdr_addr;
        n_hdr_fc   = r_hdr_fc;
        n_exp_cnt  = r_exp_cnt;
        n_byte_cnt = r_byte_cnt;
        n_crc_lo   = r_crc_lo;
        n_tick     = r_tick;
        n_first    = r_first;

        o_push.valid        = 1'b0;
        o_push.entry.kind   = mrf_pkg::KIND_TX;
        o_push.entry.cnt    = 2'd0;
        o_push.entry.bytes  = '0;
        o_push.entry.status = mrf_pkg::ST_OK;
        o_push.entry.exc    = 8'd0;
        o_push.entry.plen   = 8'd0;

        if (accept) begin
            case (mrf_pkg::t_op'(i_in.op))
                mrf_pkg::OP_PDU: begin
                    if (r_phase == mrf_pkg::PH_IDLE) begin
                        o_push.valid = 1'b1;
                        n_crc        = crc_b;
                        if (r_first) begin
                            o_push.entry.bytes = {crc_b[15:8], crc_b[7:0], b, r_slave_addr};
                            o_push.entry.cnt   = i_in.last_flag ? 2'd3 : 2'd1;
                            n_req_fc           = b;
                            n_first            = 1'b0;
                        end else begin
                            o_push.entry.bytes = {8'd0, crc_b[15:8], crc_b[7:0], b};
                            o_push.entry.cnt   = i_in.last_flag ? 2'd2 : 2'd0;
                        end
                        if (i_in.last_flag) begin
                            n_crc      = mrf_pkg::CRC_INIT;
                            n_tick     = 16'd0;
                            n_byte_cnt = 8'd0;
                            n_first    = 1'b1;
                            n_phase    = mrf_pkg::PH_H0;
                        end
                    end
                end
                mrf_pkg::OP_RX: begin
                    case (r_phase)
                        mrf_pkg::PH_H0: begin
                            n_hdr_addr = b;
                            n_crc      = crc_rx;
                            n_phase    = mrf_pkg::PH_H1;
                        end
                        mrf_pkg::PH_H1: begin
                            n_hdr_fc = b;
                            n_crc    = crc_rx;
                            n_phase  = mrf_pkg::PH_H2;
                        end
                        mrf_pkg::PH_H2: begin
                            n_crc = crc_rx;
                            o_push.entry.kind = mrf_pkg::KIND_VERDICT;
                            if (r_hdr_addr != r_slave_addr) begin
                                o_push.valid        = 1'b1;
                                o_push.entry.status = mrf_pkg::ST_BAD_RESP;
                                n_phase             = mrf_pkg::PH_IDLE;
                            end else if (r_hdr_fc == (r_req_fc | mrf_pkg::EXC_FLAG)) begin
                                // exception reply ends at once, no CRC check
                                o_push.valid        = 1'b1;
                                o_push.entry.status = mrf_pkg::ST_EXCEPTION;
                                o_push.entry.exc    = b;
                                n_phase             = mrf_pkg::PH_IDLE;
                            end else if (r_hdr_fc != r_req_fc) begin
                                o_push.valid        = 1'b1;
                                o_push.entry.status = mrf_pkg::ST_BAD_RESP;
                                n_phase             = mrf_pkg::PH_IDLE;
                            end else if (r_req_fc <= mrf_pkg::READ_FC_MAX) begin
                                if (b == 8'd0 || b > r_max_payload || b > mrf_pkg::MAX_DATA) begin
                                    o_push.valid        = 1'b1;
                                    o_push.entry.status = mrf_pkg::ST_BAD_RESP;
                                    n_phase             = mrf_pkg::PH_IDLE;
                                end else begin
                                    n_exp_cnt  = b;
                                    n_byte_cnt = 8'd0;
                                    n_phase    = mrf_pkg::PH_DATA;
                                end
                            end else begin
                                n_byte_cnt = mrf_pkg::ECHO_START;
                                n_phase    = mrf_pkg::PH_ECHO;
                            end
                        end
                        mrf_pkg::PH_DATA: begin
                            n_crc      = crc_rx;
                            n_byte_cnt = cnt_inc;
                            if (cnt_inc >= r_exp_cnt) begin
                                n_phase = mrf_pkg::PH_CRCL;
                            end
                            o_push.valid          = 1'b1;
                            o_push.entry.kind     = mrf_pkg::KIND_PAYLOAD;
                            o_push.entry.bytes[0] = b;
                        end
                        mrf_pkg::PH_ECHO: begin
                            n_crc      = crc_rx;
                            n_byte_cnt = cnt_inc;
                            if (cnt_inc >= mrf_pkg::ECHO_LEN) begin
                                n_phase = mrf_pkg::PH_CRCL;
                            end
                        end
                        mrf_pkg::PH_CRCL: begin
                            n_crc_lo = b;
                            n_phase  = mrf_pkg::PH_CRCH;
                        end
                        mrf_pkg::PH_CRCH: begin
                            o_push.valid      = 1'b1;
                            o_push.entry.kind = mrf_pkg::KIND_VERDICT;
                            n_phase           = mrf_pkg::PH_IDLE;
                            if (r_crc != {b, r_crc_lo}) begin
                                o_push.entry.status = mrf_pkg::ST_CRC_ERR;
                            end else if (r_req_fc <= mrf_pkg::READ_FC_MAX) begin
                                o_push.entry.plen = r_exp_cnt;
                            end
                        end
                        default: ;
                    endcase
                end
                mrf_pkg::OP_TICK: begin
                    if (r_phase != mrf_pkg::PH_IDLE) begin
                        n_tick = tick_inc;
                        if (tick_inc >= r_timeout) begin
                            o_push.valid        = 1'b1;
                            o_push.entry.kind   = mrf_pkg::KIND_VERDICT;
                            o_push.entry.status = mrf_pkg::ST_TIMEOUT;
                            n_phase             = mrf_pkg::PH_IDLE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/mrf_queue.sv
// Result-group queue between the front end and the output sequencer.
// Depends on mrf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrf_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mrf_pkg::t_push i_push,
    input  wire logic          i_pop,
    output logic               o_full,
    output mrf_pkg::t_head     o_head
);

    localparam logic [mrf_pkg::QAW:0] DEPTH = (mrf_pkg::QAW + 1)'(mrf_pkg::QDEPTH);

    mrf_pkg::t_entry           r_mem [mrf_pkg::QDEPTH];
    logic [mrf_pkg::QAW-1:0]   r_wp;
    logic [mrf_pkg::QAW-1:0]   r_rp;
    logic [mrf_pkg::QAW:0]     r_cnt;
    logic                      do_push;
    logic                      do_pop;

    assign o_full       = (r_cnt == DEPTH);
    assign o_head.valid = (r_cnt != '0);
    assign o_head.entry = r_mem[r_rp];
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.entry;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: hdl/mrf_back.sv
// Output sequencer: unpacks queued result groups into single results.
// Depends on mrf_pkg and mrf_out_if.
`timescale 1ns / 1ps
`default_nettype none

module mrf_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire mrf_pkg::t_head i_head,
    output logic               o_pop,
    mrf_out_if.source          o_out
);

    logic            r_valid;
    logic [1:0]      r_idx;
    mrf_pkg::t_kind  r_kind;
    logic [7:0]      r_byte;
    mrf_pkg::t_status r_status;
    logic [7:0]      r_exc;
    logic [7:0]      r_plen;
    logic            r_last;

    logic            load;
    logic            grp_end;

    assign load    = i_head.valid && (!r_valid || o_out.ready);
    assign grp_end = (r_idx == i_head.entry.cnt);
    assign o_pop   = load && grp_end;

    // Control: output valid and position within the group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= grp_end ? 2'd0 : r_idx + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind   <= i_head.entry.kind;
            r_byte   <= i_head.entry.bytes[r_idx];
            r_status <= i_head.entry.status;
            r_exc    <= i_head.entry.exc;
            r_plen   <= i_head.entry.plen;
            r_last   <= grp_end;
        end
    end

    assign o_out.valid          = r_valid;
    assign o_out.kind           = r_kind;
    assign o_out.out_byte       = r_byte;
    assign o_out.status         = r_status;
    assign o_out.exception_code = r_exc;
    assign o_out.payload_len    = r_plen;
    assign o_out.last           = r_last;

endmodule

`default_nettype wire

// File: hdl/modbus_rtu_master_framer_core.sv
// Top level of the Modbus RTU master framer: front end, result queue, sequencer.
// Depends on mrf_pkg, mrf_in_if, mrf_out_if, mrf_front, mrf_queue, mrf_back.
//
//  Channel  Direction  Handshake      Payload
//  i_in     in         valid/ready    op, data_byte, last_flag
//  o_out    out        valid/ready    kind, out_byte, status, exception_code,
//                                     payload_len, last
//  i_cfg_*  in         write enable   register index, 16-bit data
//
// One input transaction is accepted per cycle while the four-entry result queue
// has room; its state update (including up to two CRC byte updates) is done in
// that cycle. Results leave one per cycle from a registered output stage while
// the sink is ready; a request byte can cause up to four results in one group.
// Reset is synchronous, active low; no clearing pass. Either side may stall.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_master_framer_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    mrf_in_if.sink           i_in,
    mrf_out_if.source        o_out,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);

    mrf_pkg::t_push push;
    mrf_pkg::t_head head;
    logic           q_full;
    logic           pop;

    mrf_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (q_full),
        .o_push     (push)
    );

    mrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_head  (head)
    );

    mrf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
